### rtl/bls_pkg.sv
// shared types and constants for the bresenham line stepper
// no dependencies
`timescale 1ns / 1ps

package bls_pkg;

    // command codes carried on the input channel
    typedef enum logic [0:0] {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } t_opcode;

    // extra bits of the error term above the coordinate width
    localparam int ERR_GUARD_BITS = 4;

endpackage

### rtl/bls_if.sv
// stream interfaces for commands and pixels of the line stepper
// depends on bls_pkg
`timescale 1ns / 1ps

interface bls_cmd_if #(
    parameter int COORD_BITS = 12
);
    import bls_pkg::*;

    logic                         valid;
    logic                         ready;
    t_opcode                      opcode;
    logic signed [COORD_BITS-1:0] x_from;
    logic signed [COORD_BITS-1:0] y_from;
    logic signed [COORD_BITS-1:0] x_to;
    logic signed [COORD_BITS-1:0] y_to;

    modport source (output valid, opcode, x_from, y_from, x_to, y_to, input ready);
    modport sink   (input valid, opcode, x_from, y_from, x_to, y_to, output ready);
endinterface

interface bls_pix_if #(
    parameter int COORD_BITS = 12
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic                         more;

    modport source (output valid, pixel_x, pixel_y, more, input ready);
    modport sink   (input valid, pixel_x, pixel_y, more, output ready);
endinterface

### rtl/bls_in_reg.sv
// input register stage for line stepper commands
// depends on bls_pkg and bls_if
`timescale 1ns / 1ps

module bls_in_reg #(
    parameter int COORD_BITS = 12
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bls_cmd_if.sink   i_cmd,
    bls_cmd_if.source o_cmd
);
    import bls_pkg::*;

    logic                  r_valid;
    t_opcode               r_opcode;
    logic [COORD_BITS-1:0] r_x_from;
    logic [COORD_BITS-1:0] r_y_from;
    logic [COORD_BITS-1:0] r_x_to;
    logic [COORD_BITS-1:0] r_y_to;
    logic                  w_ready;

    // stage is free when empty or when its item moves on
    assign w_ready     = !r_valid || o_cmd.ready;
    assign i_cmd.ready = w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready && i_cmd.valid) begin
            r_opcode <= i_cmd.opcode;
            r_x_from <= i_cmd.x_from;
            r_y_from <= i_cmd.y_from;
            r_x_to   <= i_cmd.x_to;
            r_y_to   <= i_cmd.y_to;
        end
    end

    assign o_cmd.valid  = r_valid;
    assign o_cmd.opcode = r_opcode;
    assign o_cmd.x_from = r_x_from;
    assign o_cmd.y_from = r_y_from;
    assign o_cmd.x_to   = r_x_to;
    assign o_cmd.y_to   = r_y_to;

endmodule

### rtl/bls_core.sv
// line state, setup and step logic with the result register
// depends on bls_pkg and bls_if
`timescale 1ns / 1ps

module bls_core #(
    parameter int COORD_BITS = 12
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bls_cmd_if.sink   i_item,
    bls_pix_if.source o_pix
);
    import bls_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int DB = COORD_BITS + 1;
    localparam int EB = COORD_BITS + ERR_GUARD_BITS;

    // line state
    logic [CB-1:0]        r_cur_x, r_cur_y, r_end_x, r_end_y;
    logic [CB-1:0]        n_cur_x, n_cur_y, n_end_x, n_end_y;
    logic [DB-1:0]        r_tdx, r_tdy, n_tdx, n_tdy;
    logic signed [EB-1:0] r_err, n_err;
    logic                 r_x_neg, r_y_neg, r_x_major, r_tie, r_line_valid;
    logic                 n_x_neg, n_y_neg, n_x_major, n_tie, n_line_valid;

    // result register
    logic                 r_pix_valid;
    logic [CB-1:0]        r_px, r_py;
    logic                 r_more;

    logic                 w_adv, w_take;

    // setup terms
    logic signed [CB:0]   s_dx, s_dy, s_adx_w, s_ady_w;
    logic [CB-1:0]        s_adx, s_ady;
    logic                 s_x_major;

    // step terms
    logic                 t_minor, t_at_end;
    logic [DB-1:0]        t_major_d, t_minor_d;
    logic [CB-1:0]        t_inc_x, t_inc_y;

    assign w_adv        = !r_pix_valid || o_pix.ready;
    assign w_take       = w_adv && i_item.valid;
    assign i_item.ready = w_adv;

    always_comb begin
        s_dx      = $signed({i_item.x_to[CB-1], i_item.x_to})
                  - $signed({i_item.x_from[CB-1], i_item.x_from});
        s_dy      = $signed({i_item.y_to[CB-1], i_item.y_to})
                  - $signed({i_item.y_from[CB-1], i_item.y_from});
        s_adx_w   = s_dx[CB] ? -s_dx : s_dx;
        s_ady_w   = s_dy[CB] ? -s_dy : s_dy;
        s_adx     = s_adx_w[CB-1:0];
        s_ady     = s_ady_w[CB-1:0];
        s_x_major = s_adx > s_ady;
    end

    always_comb begin
        t_minor   = (r_err > 0) || ((r_err == '0) && r_tie);
        t_at_end  = r_x_major ? (r_cur_x == r_end_x) : (r_cur_y == r_end_y);
        t_major_d = r_x_major ? r_tdx : r_tdy;
        t_minor_d = r_x_major ? r_tdy : r_tdx;
        t_inc_x   = r_x_neg ? '1 : CB'(1);
        t_inc_y   = r_y_neg ? '1 : CB'(1);
    end

    always_comb begin
        n_cur_x      = r_cur_x;
        n_cur_y      = r_cur_y;
        n_end_x      = r_end_x;
        n_end_y      = r_end_y;
        n_tdx        = r_tdx;
        n_tdy        = r_tdy;
        n_err        = r_err;
        n_x_neg      = r_x_neg;
        n_y_neg      = r_y_neg;
        n_x_major    = r_x_major;
        n_tie        = r_tie;
        n_line_valid = r_line_valid;
        if (w_take) begin
            if (i_item.opcode == OP_START) begin
                n_cur_x   = i_item.x_from;
                n_cur_y   = i_item.y_from;
                n_end_x   = i_item.x_to;
                n_end_y   = i_item.y_to;
                n_x_neg   = s_dx[CB];
                n_y_neg   = s_dy[CB];
                n_tdx     = {s_adx, 1'b0};
                n_tdy     = {s_ady, 1'b0};
                n_x_major = s_x_major;
                if (s_x_major) begin
                    n_tie        = !s_dx[CB];
                    n_err        = $signed(EB'({s_ady, 1'b0}) - EB'(s_adx));
                    n_line_valid = i_item.x_from != i_item.x_to;
                end else begin
                    n_tie        = !s_dy[CB];
                    n_err        = $signed(EB'({s_adx, 1'b0}) - EB'(s_ady));
                    n_line_valid = i_item.y_from != i_item.y_to;
                end
            end else if (r_line_valid) begin
                if (t_at_end) begin
                    n_line_valid = 1'b0;
                end else begin
                    n_err = $signed(EB'(r_err) - (t_minor ? EB'(t_major_d) : EB'(0))
                                    + EB'(t_minor_d));
                    if (r_x_major || t_minor) begin
                        n_cur_x = r_cur_x + t_inc_x;
                    end
                    if (!r_x_major || t_minor) begin
                        n_cur_y = r_cur_y + t_inc_y;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_valid <= 1'b0;
            r_x_neg      <= 1'b0;
            r_y_neg      <= 1'b0;
            r_x_major    <= 1'b0;
            r_tie        <= 1'b0;
            r_pix_valid  <= 1'b0;
        end else begin
            r_line_valid <= n_line_valid;
            r_x_neg      <= n_x_neg;
            r_y_neg      <= n_y_neg;
            r_x_major    <= n_x_major;
            r_tie        <= n_tie;
            if (w_adv) begin
                r_pix_valid <= i_item.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x <= '0;
            r_cur_y <= '0;
            r_end_x <= '0;
            r_end_y <= '0;
            r_tdx   <= '0;
            r_tdy   <= '0;
            r_err   <= '0;
        end else begin
            r_cur_x <= n_cur_x;
            r_cur_y <= n_cur_y;
            r_end_x <= n_end_x;
            r_end_y <= n_end_y;
            r_tdx   <= n_tdx;
            r_tdy   <= n_tdy;
            r_err   <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_more <= n_line_valid;
            r_px   <= n_line_valid ? n_cur_x : '0;
            r_py   <= n_line_valid ? n_cur_y : '0;
        end
    end

    assign o_pix.valid   = r_pix_valid;
    assign o_pix.pixel_x = r_px;
    assign o_pix.pixel_y = r_py;
    assign o_pix.more    = r_more;

    // a pixel without a fragment reads as the origin
    a_idle_pixel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pix_valid && !r_more |-> (r_px == '0) && (r_py == '0))
        else $error("pixel not zero while more is low");

    // a step on a finished line leaves it finished
    a_dead_line_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take && (i_item.opcode == OP_STEP) && !r_line_valid |=> !r_line_valid)
        else $error("step revived an invalid line");

    // a zero-length line never reports a fragment
    a_zero_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take && (i_item.opcode == OP_START) && (i_item.x_from == i_item.x_to)
        && (i_item.y_from == i_item.y_to) |=> !r_more && !r_line_valid)
        else $error("zero-length line reported as valid");

    // a step short of the end moves the major coordinate
    a_major_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take && (i_item.opcode == OP_STEP) && r_line_valid && r_x_major
        && (r_cur_x != r_end_x) |=> r_cur_x != $past(r_cur_x))
        else $error("x-major step did not move x");

endmodule

### rtl/bresenham_line_stepper.sv
// top level of the bresenham line stepper: input register stage and core
// depends on bls_pkg, bls_if, bls_in_reg and bls_core
// a command passes the input register and then the result register before its pixel is valid
// throughput: one command and one pixel per cycle while the pixel receiver stays ready
// the input register and result register each decouple the channels
// reset (synchronous, active low) empties both stages and unloads the line
`timescale 1ns / 1ps

module bresenham_line_stepper #(
    parameter int COORD_BITS = 12
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bls_cmd_if.sink   i_cmd,
    bls_pix_if.source o_pix
);
    import bls_pkg::*;

    // command stream between the input register and the core
    bls_cmd_if #(.COORD_BITS(COORD_BITS)) w_item ();

    // register each command transfer so the setup math starts from a flop
    bls_in_reg #(
        .COORD_BITS (COORD_BITS)
    ) u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .o_cmd   (w_item.source)
    );

    // start setup or one pixel step per cycle while the pixel receiver is ready, result held in an output register
    bls_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (w_item.sink),
        .o_pix   (o_pix)
    );

endmodule
